### src/cou_pkg.sv
// Shared types, fixed-point constants and helpers for the camera orientation block.
// Used by cou_div, cou_isqrt and camera_orientation_update; depends on nothing.

package cou_pkg;

  localparam int WORD_WIDTH   = 32;
  localparam int FRAC         = 30;
  localparam int ANG_W        = 36;
  localparam int CORDIC_STEPS = 30;
  localparam int DIV_W        = 64;
  localparam int RAD_W        = 64;
  localparam int IN_TDATA_W   = ((4 * WORD_WIDTH + 1 + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = 9 * WORD_WIDTH;

  typedef logic signed [WORD_WIDTH-1:0] word_t;
  typedef logic signed [ANG_W-1:0]      ang_t;

  localparam logic signed [63:0] WMAX = (64'sd1 <<< (WORD_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;
  localparam word_t ONE_W = word_t'(64'sd1 <<< FRAC);

  // Angles in Q.30 carried in ANG_W bits
  localparam ang_t PI_A      = 36'sd3373259426;
  localparam ang_t TWO_PI_A  = 36'sd6746518852;
  localparam ang_t HALF_PI_A = 36'sd1686629713;
  localparam ang_t CORDIC_K  = 36'sd652032874;

  // Clamp a wide signed value to the word range
  function automatic word_t sat_w(input logic signed [63:0] v);
    word_t r;
    if (v > WMAX) begin
      r = word_t'(WMAX);
    end else if (v < WMIN) begin
      r = word_t'(WMIN);
    end else begin
      r = word_t'(v);
    end
    return r;
  endfunction

  // Q2.30 product: floor shift then clamp
  function automatic word_t mulq(input logic signed [63:0] p);
    return sat_w(p >>> FRAC);
  endfunction

  // CORDIC arctangent steps, Q.30
  function automatic ang_t atan_at(input logic [4:0] i);
    ang_t r;
    case (i)
      5'd0:    r = 36'sd843314857;
      5'd1:    r = 36'sd497837829;
      5'd2:    r = 36'sd263043837;
      5'd3:    r = 36'sd133525159;
      5'd4:    r = 36'sd67021687;
      5'd5:    r = 36'sd33543516;
      5'd6:    r = 36'sd16775851;
      5'd7:    r = 36'sd8388437;
      5'd8:    r = 36'sd4194283;
      5'd9:    r = 36'sd2097149;
      5'd10:   r = 36'sd1048576;
      5'd11:   r = 36'sd524288;
      5'd12:   r = 36'sd262144;
      5'd13:   r = 36'sd131072;
      5'd14:   r = 36'sd65536;
      5'd15:   r = 36'sd32768;
      5'd16:   r = 36'sd16384;
      5'd17:   r = 36'sd8192;
      5'd18:   r = 36'sd4096;
      5'd19:   r = 36'sd2048;
      5'd20:   r = 36'sd1024;
      5'd21:   r = 36'sd512;
      5'd22:   r = 36'sd256;
      5'd23:   r = 36'sd128;
      5'd24:   r = 36'sd64;
      5'd25:   r = 36'sd32;
      5'd26:   r = 36'sd16;
      5'd27:   r = 36'sd8;
      5'd28:   r = 36'sd4;
      5'd29:   r = 36'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### src/cou_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on cou_pkg for widths; quotient must fit in a word.

module cou_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cou_pkg::DIV_W-1:0]      dividend,
  input  logic [cou_pkg::WORD_WIDTH-1:0] divisor,
  output logic                           done,
  output logic [cou_pkg::WORD_WIDTH-1:0] quotient
);

  localparam int W     = cou_pkg::WORD_WIDTH;
  localparam int DW    = cou_pkg::DIV_W;
  localparam int CNT_W = $clog2(DW);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    quo;
  logic [W-1:0]     rem;
  logic [W-1:0]     den;
  logic [W:0]       trial;
  logic [W:0]       diff;
  logic             fits;

  // Trial subtract of the next dividend bit
  assign trial    = {rem, quo[DW-1]};
  assign diff     = trial - {1'b0, den};
  assign fits     = trial >= {1'b0, den};
  assign quotient = quo[W-1:0];

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out and the quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], fits};
      rem <= fits ? diff[W-1:0] : trial[W-1:0];
    end
  end

endmodule

### src/cou_isqrt.sv
// Digit-by-digit floor integer square root, one result bit per cycle.
// Depends on cou_pkg for widths.

module cou_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cou_pkg::RAD_W-1:0]      radicand,
  output logic                           done,
  output logic [cou_pkg::WORD_WIDTH-1:0] root
);

  localparam int RW    = cou_pkg::RAD_W;
  localparam int STEPS = RW / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RW-1:0]    v;
  logic [RW-1:0]    res;
  logic [RW-1:0]    bitm;
  logic [RW-1:0]    sum;
  logic             ge;

  assign sum  = res + bitm;
  assign ge   = v >= sum;
  assign root = res[cou_pkg::WORD_WIDTH-1:0];

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Subtract the trial square and shift the probe bit down two places
  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      res  <= '0;
      bitm <= RW'(1) << (RW - 2);
    end else if (busy) begin
      v    <= ge ? v - sum : v;
      res  <= ge ? (res >> 1) + bitm : (res >> 1);
      bitm <= bitm >> 2;
    end
  end

endmodule

### src/camera_orientation_update.sv
// Camera orientation keeper: Q2.30 3x3 matrix, rotate and look-at commands.
// Uses cou_pkg, cou_div and cou_isqrt.
//
// Usage:
//   Input requests arrive on s_axis; tuser carries the command (0 rotate,
//   1 look-at), tdata the target or axis, the angle and the side sign.
//   Every request returns one result on m_axis with all nine matrix entries
//   and a degenerate flag in tuser. The user must write the camera position
//   on cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
// Sequencing:
//   One request at a time; s_axis_tready is high only when idle.
//   A look-at ends early when the view turns out degenerate.
//   The time is set by one shared 32x32 multiplier, 30 CORDIC iterations,
//   the bit-serial divider (six quotients per look-at) and the 32-step
//   square root (twice).
// Reset:
//   The matrix returns to identity, the camera position to zero, no result
//   is pending.
// Stalls:
//   A finished result waits in the output register; the next request is
//   accepted meanwhile and held at its end until the result is taken.

module camera_orientation_update (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // vec_x, vec_y, vec_z, turn_angle, flip_direction, zero fill
  input  logic [cou_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // action
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [cou_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // degenerate
  output logic                            m_axis_tuser,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [cou_pkg::WORD_WIDTH-1:0]  cfg_data
);

  localparam int W     = cou_pkg::WORD_WIDTH;
  localparam int FR    = cou_pkg::FRAC;
  localparam int ACC_W = 36;

  localparam logic [1:0] REG_CAM_X = 2'd0;
  localparam logic [1:0] REG_CAM_Y = 2'd1;
  localparam logic [1:0] REG_CAM_Z = 2'd2;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_PREP   = 5'd1;
  localparam logic [4:0] ST_NSCALE = 5'd2;
  localparam logic [4:0] ST_NSQ    = 5'd3;
  localparam logic [4:0] ST_NSQRT  = 5'd4;
  localparam logic [4:0] ST_NDIV   = 5'd5;
  localparam logic [4:0] ST_ANG    = 5'd6;
  localparam logic [4:0] ST_FOLD   = 5'd7;
  localparam logic [4:0] ST_CORD   = 5'd8;
  localparam logic [4:0] ST_CSFIN  = 5'd9;
  localparam logic [4:0] ST_RT1    = 5'd10;
  localparam logic [4:0] ST_RT2    = 5'd11;
  localparam logic [4:0] ST_RT3    = 5'd12;
  localparam logic [4:0] ST_RT4    = 5'd13;
  localparam logic [4:0] ST_MM     = 5'd14;
  localparam logic [4:0] ST_COPY   = 5'd15;
  localparam logic [4:0] ST_QDIV   = 5'd16;
  localparam logic [4:0] ST_XR     = 5'd17;
  localparam logic [4:0] ST_Y      = 5'd18;
  localparam logic [4:0] ST_STORE  = 5'd19;
  localparam logic [4:0] ST_DONE   = 5'd20;

  localparam logic signed [33:0] ONE_34 = 34'sd1 <<< FR;

  // Row-major index of a 3x3 entry
  function automatic logic [3:0] mi(input logic [1:0] r, input logic [1:0] c);
    return ({2'b00, r} * 4'd3) + {2'b00, c};
  endfunction

  function automatic logic [1:0] nxt1(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] nxt2(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      default: r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [32:0] abs34(input logic signed [33:0] v);
    logic signed [33:0] a;
    a = (v < 0) ? -v : v;
    return a[32:0];
  endfunction

  // Control
  logic [4:0] state;
  logic       ph;
  logic [1:0] ci, cj, ck;
  logic [4:0] idx;
  logic       act, flip, degen, ntgt, cneg;

  // Operands and working storage
  cou_pkg::word_t vin [3];
  cou_pkg::word_t ang_in;
  cou_pkg::word_t cam [3];
  cou_pkg::word_t mat [9];
  cou_pkg::word_t rm  [9];
  cou_pkg::word_t tmp [9];
  cou_pkg::word_t av  [3];
  cou_pkg::word_t sk  [3];
  cou_pkg::word_t xv  [2];
  cou_pkg::word_t xr  [3];
  cou_pkg::word_t yv  [3];
  cou_pkg::word_t c_q, s_q, omc, nrm;
  logic [32:0]    mag  [3];
  logic           mneg [3];
  logic [63:0]    nsum;
  logic signed [ACC_W-1:0] acc;
  cou_pkg::ang_t  ca, cx, cy;

  // Shared multiplier
  cou_pkg::word_t      ma, mb;
  logic signed [63:0]  p;
  cou_pkg::word_t      pq;
  logic signed [63:0]  psh;

  cou_pkg::word_t rm_rd, mat_rd;
  logic [3:0]     rm_ra;
  logic [32:0]    m_max;

  // Divider and square-root hookup
  logic                   dv_start, dv_done;
  logic [cou_pkg::DIV_W-1:0] dv_dividend;
  logic [W-1:0]           dv_divisor, dv_quot;
  logic                   sq_start, sq_done;
  logic [W-1:0]           sq_root;

  // Look-at side vector terms
  logic [32:0]        az0, az1, q_num, q_den;
  logic               z0lt, q_sgn;
  logic signed [33:0] qs, qside, sgn, xs0, xs1, uq;

  logic mult_ph;

  assign s_axis_tready = (state == ST_IDLE);

  // Register file reads
  always_comb begin
    case (state)
      ST_MM, ST_XR: rm_ra = mi(ci, ck);
      default:      rm_ra = mi(ci, cj);
    endcase
  end
  assign rm_rd  = rm[rm_ra];
  assign mat_rd = mat[mi(ck, cj)];

  // Largest magnitude for normalization
  always_comb begin
    m_max = mag[0];
    if (mag[1] > m_max) m_max = mag[1];
    if (mag[2] > m_max) m_max = mag[2];
  end

  // Multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_NSQ: begin
        ma = $signed(mag[ck][W-1:0]);
        mb = $signed(mag[ck][W-1:0]);
      end
      ST_RT1: begin
        ma = av[ci];
        mb = av[cj];
      end
      ST_RT2: begin
        ma = rm_rd;
        mb = omc;
      end
      ST_RT3: begin
        ma = av[ck];
        mb = s_q;
      end
      ST_MM: begin
        ma = rm_rd;
        mb = mat_rd;
      end
      ST_XR: begin
        ma = rm_rd;
        mb = xv[ck[0]];
      end
      ST_Y: begin
        if (ck == 2'd0) begin
          ma = av[nxt1(ci)];
          mb = xr[nxt2(ci)];
        end else begin
          ma = av[nxt2(ci)];
          mb = xr[nxt1(ci)];
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
  end

  assign pq  = cou_pkg::mulq(p);
  assign psh = p >>> FR;

  // Side vector quotient terms
  assign az0   = abs34(34'(av[0]));
  assign az1   = abs34(34'(av[1]));
  assign z0lt  = az0 < az1;
  assign q_num = z0lt ? az0 : az1;
  assign q_den = z0lt ? az1 : az0;
  assign q_sgn = av[0][W-1] ^ av[1][W-1];
  assign qs    = q_sgn ? -$signed(34'(dv_quot)) : $signed(34'(dv_quot));
  assign qside = flip ? qs : -qs;
  assign sgn   = flip ? -ONE_34 : ONE_34;
  assign xs0   = z0lt ? sgn : qside;
  assign xs1   = z0lt ? qside : sgn;
  assign uq    = mneg[ck] ? -$signed(34'(dv_quot)) : $signed(34'(dv_quot));

  // Divider and root requests
  assign dv_start   = (state == ST_NDIV || state == ST_QDIV) && !ph;
  assign dv_dividend = (state == ST_QDIV) ? 64'({q_num, {FR{1'b0}}})
                                          : 64'({mag[ck], {FR{1'b0}}});
  assign dv_divisor = (state == ST_QDIV) ? q_den[W-1:0] : nrm;
  assign sq_start   = (state == ST_NSQRT) && !ph;

  assign mult_ph = ph;

  cou_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .done     (dv_done),
    .quotient (dv_quot)
  );

  cou_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (nsum),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ph            <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 3; i++) cam[i] <= '0;
      for (int i = 0; i < 9; i++) begin
        mat[i] <= (i == 0 || i == 4 || i == 8) ? cou_pkg::ONE_W : '0;
      end
    end else begin
      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CAM_X: cam[0] <= cfg_data;
          REG_CAM_Y: cam[1] <= cfg_data;
          REG_CAM_Z: cam[2] <= cfg_data;
          default: ;
        endcase
      end

      // Drop the result once taken
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) m_axis_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            act    <= s_axis_tuser;
            vin[0] <= s_axis_tdata[W-1:0];
            vin[1] <= s_axis_tdata[2*W-1:W];
            vin[2] <= s_axis_tdata[3*W-1:2*W];
            ang_in <= s_axis_tdata[4*W-1:3*W];
            flip   <= s_axis_tdata[4*W];
            degen  <= 1'b0;
            state  <= ST_PREP;
          end
        end

        // Axis to Q2.30, or view vector magnitudes
        ST_PREP: begin
          if (act) begin
            for (int i = 0; i < 3; i++) begin
              mag[i]  <= abs34(34'(vin[i]) - 34'(cam[i]));
              mneg[i] <= (34'(vin[i]) - 34'(cam[i])) < 0;
            end
            ntgt  <= 1'b0;
            state <= ST_NSCALE;
          end else begin
            for (int i = 0; i < 3; i++) av[i] <= cou_pkg::sat_w(64'(vin[i]) <<< 6);
            state <= ST_ANG;
          end
        end

        // Scale magnitudes one bit a cycle into range
        ST_NSCALE: begin
          if (m_max == '0) begin
            degen <= 1'b1;
            state <= ST_DONE;
          end else if (m_max[32:30] != 3'd0) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (!m_max[29]) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            nsum  <= '0;
            ck    <= 2'd0;
            ph    <= 1'b0;
            state <= ST_NSQ;
          end
        end

        // Sum of squares
        ST_NSQ: begin
          if (!mult_ph) begin
            ph <= 1'b1;
          end else begin
            ph   <= 1'b0;
            nsum <= nsum + $unsigned(p);
            if (ck == 2'd2) begin
              state <= ST_NSQRT;
            end else begin
              ck <= ck + 2'd1;
            end
          end
        end

        ST_NSQRT: begin
          if (!ph) begin
            ph <= 1'b1;
          end else if (sq_done) begin
            nrm   <= sq_root;
            ck    <= 2'd0;
            ph    <= 1'b0;
            state <= ST_NDIV;
          end
        end

        // Unit components, one quotient each
        ST_NDIV: begin
          if (!ph) begin
            ph <= 1'b1;
          end else if (dv_done) begin
            ph <= 1'b0;
            if (!ntgt) begin
              av[ck] <= cou_pkg::word_t'(uq);
              if (ck == 2'd2) begin
                if (av[0] == '0 && av[1] == '0) begin
                  degen <= 1'b1;
                  state <= ST_DONE;
                end else begin
                  state <= ST_ANG;
                end
              end else begin
                ck <= ck + 2'd1;
              end
            end else begin
              xv[ck[0]] <= cou_pkg::word_t'(uq);
              if (ck == 2'd1) begin
                ci    <= 2'd0;
                ck    <= 2'd0;
                acc   <= '0;
                state <= ST_XR;
              end else begin
                ck <= ck + 2'd1;
              end
            end
          end
        end

        // Angle reduction into [-pi, pi]
        ST_ANG: begin
          if ((cou_pkg::ang_t'(ang_in) <<< 2) > cou_pkg::PI_A) begin
            ca <= (cou_pkg::ang_t'(ang_in) <<< 2) - cou_pkg::TWO_PI_A;
          end else if ((cou_pkg::ang_t'(ang_in) <<< 2) < -cou_pkg::PI_A) begin
            ca <= (cou_pkg::ang_t'(ang_in) <<< 2) + cou_pkg::TWO_PI_A;
          end else begin
            ca <= cou_pkg::ang_t'(ang_in) <<< 2;
          end
          state <= ST_FOLD;
        end

        // Fold into [-pi/2, pi/2] and seed CORDIC
        ST_FOLD: begin
          if (ca > cou_pkg::HALF_PI_A) begin
            ca   <= ca - cou_pkg::PI_A;
            cneg <= 1'b1;
          end else if (ca < -cou_pkg::HALF_PI_A) begin
            ca   <= ca + cou_pkg::PI_A;
            cneg <= 1'b1;
          end else begin
            cneg <= 1'b0;
          end
          cx    <= cou_pkg::CORDIC_K;
          cy    <= '0;
          idx   <= '0;
          state <= ST_CORD;
        end

        // One rotation step a cycle
        ST_CORD: begin
          if (ca >= 0) begin
            cx <= cx - (cy >>> idx);
            cy <= cy + (cx >>> idx);
            ca <= ca - cou_pkg::atan_at(idx);
          end else begin
            cx <= cx + (cy >>> idx);
            cy <= cy - (cx >>> idx);
            ca <= ca + cou_pkg::atan_at(idx);
          end
          if (idx == 5'(cou_pkg::CORDIC_STEPS - 1)) begin
            state <= ST_CSFIN;
          end else begin
            idx <= idx + 5'd1;
          end
        end

        ST_CSFIN: begin
          c_q   <= cou_pkg::sat_w(64'(cneg ? -cx : cx));
          s_q   <= cou_pkg::sat_w(64'(cneg ? -cy : cy));
          ci    <= 2'd0;
          cj    <= 2'd0;
          ph    <= 1'b0;
          state <= ST_RT1;
        end

        // Outer product a*a^T
        ST_RT1: begin
          omc <= cou_pkg::sat_w(64'(cou_pkg::ONE_W) - 64'(c_q));
          if (!mult_ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            rm[mi(ci, cj)] <= pq;
            if (cj == 2'd2) begin
              cj <= 2'd0;
              if (ci == 2'd2) begin
                ci    <= 2'd0;
                state <= ST_RT2;
              end else begin
                ci <= ci + 2'd1;
              end
            end else begin
              cj <= cj + 2'd1;
            end
          end
        end

        // Scale by 1 - cos
        ST_RT2: begin
          if (!mult_ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            rm[mi(ci, cj)] <= pq;
            if (cj == 2'd2) begin
              cj <= 2'd0;
              if (ci == 2'd2) begin
                ci    <= 2'd0;
                ck    <= 2'd0;
                state <= ST_RT3;
              end else begin
                ci <= ci + 2'd1;
              end
            end else begin
              cj <= cj + 2'd1;
            end
          end
        end

        // Axis times sine
        ST_RT3: begin
          if (!mult_ph) begin
            ph <= 1'b1;
          end else begin
            ph     <= 1'b0;
            sk[ck] <= pq;
            if (ck == 2'd2) begin
              state <= ST_RT4;
            end else begin
              ck <= ck + 2'd1;
            end
          end
        end

        // Add cosine diagonal and skew terms
        ST_RT4: begin
          rm[0] <= cou_pkg::sat_w(64'(c_q) + 64'(rm[0]));
          rm[4] <= cou_pkg::sat_w(64'(c_q) + 64'(rm[4]));
          rm[8] <= cou_pkg::sat_w(64'(c_q) + 64'(rm[8]));
          rm[1] <= cou_pkg::sat_w(64'(rm[1]) - 64'(sk[2]));
          rm[2] <= cou_pkg::sat_w(64'(rm[2]) + 64'(sk[1]));
          rm[3] <= cou_pkg::sat_w(64'(rm[3]) + 64'(sk[2]));
          rm[5] <= cou_pkg::sat_w(64'(rm[5]) - 64'(sk[0]));
          rm[6] <= cou_pkg::sat_w(64'(rm[6]) - 64'(sk[1]));
          rm[7] <= cou_pkg::sat_w(64'(rm[7]) + 64'(sk[0]));
          ci  <= 2'd0;
          cj  <= 2'd0;
          ck  <= 2'd0;
          acc <= '0;
          ph  <= 1'b0;
          state <= act ? ST_QDIV : ST_MM;
        end

        // Left multiply, three floored products per entry
        ST_MM: begin
          if (!mult_ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (ck == 2'd2) begin
              tmp[mi(ci, cj)] <= cou_pkg::sat_w(64'(acc + ACC_W'(psh)));
              acc <= '0;
              ck  <= 2'd0;
              if (cj == 2'd2) begin
                cj <= 2'd0;
                if (ci == 2'd2) begin
                  state <= ST_COPY;
                end else begin
                  ci <= ci + 2'd1;
                end
              end else begin
                cj <= cj + 2'd1;
              end
            end else begin
              acc <= acc + ACC_W'(psh);
              ck  <= ck + 2'd1;
            end
          end
        end

        ST_COPY: begin
          for (int i = 0; i < 9; i++) mat[i] <= tmp[i];
          state <= ST_DONE;
        end

        // Horizontal side vector quotient
        ST_QDIV: begin
          if (!ph) begin
            ph <= 1'b1;
          end else if (dv_done) begin
            ph      <= 1'b0;
            mag[0]  <= abs34(xs0);
            mag[1]  <= abs34(xs1);
            mag[2]  <= '0;
            mneg[0] <= xs0 < 0;
            mneg[1] <= xs1 < 0;
            mneg[2] <= 1'b0;
            ntgt    <= 1'b1;
            state   <= ST_NSCALE;
          end
        end

        // Roll the side vector
        ST_XR: begin
          if (!mult_ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (ck == 2'd0) begin
              acc <= acc + ACC_W'(pq);
              ck  <= 2'd1;
            end else begin
              xr[ci] <= cou_pkg::sat_w(64'(acc + ACC_W'(pq)));
              acc    <= '0;
              ck     <= 2'd0;
              if (ci == 2'd2) begin
                ci    <= 2'd0;
                state <= ST_Y;
              end else begin
                ci <= ci + 2'd1;
              end
            end
          end
        end

        // Up vector as z cross x
        ST_Y: begin
          if (!mult_ph) begin
            ph <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (ck == 2'd0) begin
              acc <= ACC_W'(pq);
              ck  <= 2'd1;
            end else begin
              yv[ci] <= cou_pkg::sat_w(64'(acc - ACC_W'(pq)));
              ck     <= 2'd0;
              if (ci == 2'd2) begin
                state <= ST_STORE;
              end else begin
                ci <= ci + 2'd1;
              end
            end
          end
        end

        // Store columns (-y, x, z)
        ST_STORE: begin
          for (int i = 0; i < 3; i++) begin
            mat[3*i]     <= cou_pkg::sat_w(-(64'(yv[i])));
            mat[3*i + 1] <= xr[i];
            mat[3*i + 2] <= av[i];
          end
          state <= ST_DONE;
        end

        // Hold until the output register is free
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {mat[8], mat[7], mat[6], mat[5], mat[4],
                              mat[3], mat[2], mat[1], mat[0]};
            m_axis_tuser  <= degen;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_cordic_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CORD |-> idx < 5'(cou_pkg::CORDIC_STEPS))
    else $error("CORDIC step count out of range");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> (state == ST_NDIV || state == ST_QDIV) && ph)
    else $error("quotient arrived while nobody waits");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the finish state");

endmodule

### bench/tb_camera_orientation_update.sv
// Self-checking bench for camera_orientation_update: rotate and look-at requests
// checked against a bit-exact fixed-point predictor. Depends on src/cou_pkg.sv.
`timescale 1ns / 100ps

module tb_camera_orientation_update;

  localparam logic [1:0] REG_CAM_X = 2'd0;
  localparam logic [1:0] REG_CAM_Y = 2'd1;
  localparam logic [1:0] REG_CAM_Z = 2'd2;
  localparam logic ACT_ROTATE = 1'b0;
  localparam logic ACT_LOOK_AT = 1'b1;
  localparam longint ONE = 64'sd1 <<< 30;
  localparam longint PI_Q = 64'sd3373259426;
  localparam longint TWO_PI_Q = 64'sd6746518852;
  localparam longint HALF_PI_Q = 64'sd1686629713;
  localparam longint GAIN_Q = 64'sd652032874;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam longint ATAN_STEP [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct packed {
    logic               action;
    logic               flip;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] ang;
  } cmd_t;

  typedef struct packed {
    logic [cou_pkg::OUT_TDATA_W-1:0] mat;
    logic                            degen;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [cou_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [cou_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [cou_pkg::WORD_WIDTH-1:0] cfg_data = '0;

  cmd_t   pending_cmds[$];
  pose_t  expected_poses[$];
  cmd_t   cur_cmd;
  longint orient[9];
  longint cam[3];
  int     errors = 0;
  bit     quiet = 1'b0;
  int     send_gap = 0;
  int     take_gap = 0;
  longint cycles = 0;

  camera_orientation_update dut (.*);

  always #2 clk = ~clk;

  // ---------------- fixed-point predictor ----------------

  function automatic longint clamp(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return clamp((a * b) >>> 30);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Reduce angle to [-pi/2, pi/2], then 30 CORDIC rotations
  task automatic sin_cos(input longint ang, output longint c, output longint s);
    longint a, x, y, nx;
    bit neg;
    a = ang * 4;
    x = GAIN_Q;
    y = 0;
    neg = 1'b0;
    while (a > PI_Q) a = a - TWO_PI_Q;
    while (a < -PI_Q) a = a + TWO_PI_Q;
    if (a > HALF_PI_Q) begin
      a = a - PI_Q;
      neg = 1'b1;
    end else if (a < -HALF_PI_Q) begin
      a = a + PI_Q;
      neg = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        a = a - ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        a = a + ATAN_STEP[i];
      end
      x = nx;
    end
    if (neg) begin
      x = -x;
      y = -y;
    end
    c = clamp(x);
    s = clamp(y);
  endtask

  // Axis-angle matrix c*I + (1-c)*a*a^T + s*[a]x
  task automatic axis_matrix(input longint a[3], input longint c, input longint s,
                             output longint r[9]);
    longint omc;
    omc = clamp(ONE - c);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) r[i*3+j] = fmul(fmul(a[i], a[j]), omc);
    r[0] = clamp(c + r[0]);
    r[4] = clamp(c + r[4]);
    r[8] = clamp(c + r[8]);
    r[1] = clamp(r[1] - fmul(a[2], s));
    r[2] = clamp(r[2] + fmul(a[1], s));
    r[3] = clamp(r[3] + fmul(a[2], s));
    r[5] = clamp(r[5] - fmul(a[0], s));
    r[6] = clamp(r[6] - fmul(a[1], s));
    r[7] = clamp(r[7] + fmul(a[0], s));
  endtask

  // Unit vector of the first n components; ok low for a zero vector
  task automatic unit_vec(input longint v[3], input int n, output longint u[3],
                          output bit ok);
    longint unsigned mag[3], m, sum, nrm, q;
    m = 0;
    sum = 0;
    u = '{0, 0, 0};
    for (int i = 0; i < n; i++) begin
      mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > m) m = mag[i];
    end
    ok = (m != 0);
    if (ok) begin
      while (m >= (64'd1 << 30)) begin
        m = m >> 1;
        for (int i = 0; i < n; i++) mag[i] = mag[i] >> 1;
      end
      while (m < (64'd1 << 29)) begin
        m = m << 1;
        for (int i = 0; i < n; i++) mag[i] = mag[i] << 1;
      end
      for (int i = 0; i < n; i++) sum = sum + mag[i] * mag[i];
      nrm = int_root(sum);
      for (int i = 0; i < n; i++) begin
        q = (mag[i] << 30) / nrm;
        u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
  endtask

  task automatic point_at(input longint p[3], input longint ang, input bit flip,
                          output bit degen);
    longint d[3], z[3], rot[9], xs[3], x[3], xr[3], y[3], c, s, q, sgn;
    bit ok;
    sgn = flip ? -ONE : ONE;
    for (int i = 0; i < 3; i++) d[i] = p[i] - cam[i];
    unit_vec(d, 3, z, ok);
    degen = !ok || (z[0] == 0 && z[1] == 0);
    if (!degen) begin
      sin_cos(ang, c, s);
      axis_matrix(z, c, s, rot);
      // Horizontal side vector, perpendicular to the view's ground track
      if ((z[0] < 0 ? -z[0] : z[0]) < (z[1] < 0 ? -z[1] : z[1])) begin
        q = (z[0] * ONE) / z[1];
        xs[0] = sgn;
        xs[1] = flip ? q : -q;
      end else begin
        q = (z[1] * ONE) / z[0];
        xs[0] = flip ? q : -q;
        xs[1] = sgn;
      end
      xs[2] = 0;
      unit_vec(xs, 2, x, ok);
      for (int i = 0; i < 3; i++) xr[i] = clamp(fmul(rot[i*3], x[0]) + fmul(rot[i*3+1], x[1]));
      y[0] = clamp(fmul(z[1], xr[2]) - fmul(z[2], xr[1]));
      y[1] = clamp(fmul(z[2], xr[0]) - fmul(z[0], xr[2]));
      y[2] = clamp(fmul(z[0], xr[1]) - fmul(z[1], xr[0]));
      for (int i = 0; i < 3; i++) begin
        orient[i*3] = clamp(-y[i]);
        orient[i*3+1] = xr[i];
        orient[i*3+2] = z[i];
      end
    end
  endtask

  task automatic turn_about(input longint v[3], input longint ang);
    longint a[3], r[9], res[9], c, s, acc;
    for (int i = 0; i < 3; i++) a[i] = clamp(v[i] * 64);
    sin_cos(ang, c, s);
    axis_matrix(a, c, s, r);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc = acc + ((r[i*3+k] * orient[k*3+j]) >>> 30);
        res[i*3+j] = clamp(acc);
      end
    orient = res;
  endtask

  // Advance the orientation for one accepted request and queue its result
  task automatic predict_pose(input cmd_t cmd);
    longint v[3];
    pose_t e;
    bit degen;
    v = '{longint'(cmd.vx), longint'(cmd.vy), longint'(cmd.vz)};
    degen = 1'b0;
    if (cmd.action == ACT_LOOK_AT) point_at(v, longint'(cmd.ang), cmd.flip, degen);
    else turn_about(v, longint'(cmd.ang));
    for (int i = 0; i < 9; i++) e.mat[i*32 +: 32] = orient[i][31:0];
    e.degen = degen;
    expected_poses.push_back(e);
  endtask

  // ---------------- request driver ----------------

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) predict_pose(cur_cmd);
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        send_gap = $urandom_range(0, 3);
        s_axis_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cur_cmd = pending_cmds.pop_front();
        s_axis_tdata <= {7'b0, cur_cmd.flip, cur_cmd.ang, cur_cmd.vz, cur_cmd.vy,
                         cur_cmd.vx};
        s_axis_tuser <= cur_cmd.action;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- result monitor ----------------

  always @(posedge clk) begin
    pose_t e;
    string names[9];
    names = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_poses.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          e = expected_poses.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_axis_tdata[i*32 +: 32] !== e.mat[i*32 +: 32]) begin
              $error("%s: expected %0d, got %0d", names[i],
                     $signed(e.mat[i*32 +: 32]), $signed(m_axis_tdata[i*32 +: 32]));
              errors++;
            end
          if (m_axis_tuser !== e.degen) begin
            $error("degenerate: expected %0d, got %0d", e.degen, m_axis_tuser);
            errors++;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(4) == 0) begin
        take_gap = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  task automatic push_cmd(logic act, logic signed [31:0] x, logic signed [31:0] y,
                          logic signed [31:0] z, logic signed [31:0] ang, logic flip);
    cmd_t c;
    c = '{action: act, flip: flip, vx: x, vy: y, vz: z, ang: ang};
    pending_cmds.push_back(c);
  endtask

  task automatic write_reg(logic [1:0] idx, logic signed [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    cam[idx] = longint'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sample between edges so driver and monitor updates have settled
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_poses.size() != 0)
      @(negedge clk);
  endtask

  // Mostly unit-scale vectors so the look-at and rotate math stays in range
  function automatic logic signed [31:0] near_unit();
    return $urandom_range(3) == 0 ? $urandom : $signed($urandom_range(0, 1 << 26)) - (1 << 25);
  endfunction

  task automatic random_cmds(int n);
    logic act;
    for (int k = 0; k < n; k++) begin
      act = $urandom_range(1) ? ACT_LOOK_AT : ACT_ROTATE;
      if (act == ACT_LOOK_AT && $urandom_range(3) != 0)
        push_cmd(act, 32'(cam[0]) + near_unit(), 32'(cam[1]) + near_unit(),
                 32'(cam[2]) + near_unit(), $urandom, 1'($urandom_range(1)));
      else
        push_cmd(act, near_unit(), near_unit(), near_unit(), $urandom,
                 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic signed [31:0] cam_sets[6][3];
    cam_sets = '{'{0, 0, 0},
                 '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
                 '{32'sh80000000, 32'sh80000000, 32'sh80000000},
                 '{32'sh01000000, -32'sh02000000, 32'sh00800000},
                 '{0, 0, 0},
                 '{0, 0, 0}};
    orient = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    cam = '{0, 0, 0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      if (ph == 4)
        for (int i = 0; i < 3; i++) cam_sets[4][i] = $urandom;
      write_reg(REG_CAM_X, cam_sets[ph][0]);
      write_reg(REG_CAM_Y, cam_sets[ph][1]);
      write_reg(REG_CAM_Z, cam_sets[ph][2]);
      if (ph == 0) begin
        // Directed: identity axis, extremes, unnormalized and over-range axes
        push_cmd(ACT_ROTATE, 0, 0, 32'sh01000000, 32'sh10000000, 1'b0);
        push_cmd(ACT_ROTATE, 0, 0, 0, 32'sh7fffffff, 1'b1);
        push_cmd(ACT_ROTATE, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                 1'b0);
        push_cmd(ACT_ROTATE, 32'sh03000000, 32'sh00800000, -32'sh03000000, 32'sh32438000,
                 1'b1);
        push_cmd(ACT_ROTATE, 32'sh01000000, 0, 0, -32'sh32438000, 1'b0);
        push_cmd(ACT_ROTATE, 32'sh00b50000, 32'sh00b50000, 0, 32'sh40000000, 1'b0);
        // Look-at: zero view, vertical up and down, both side cases and signs
        push_cmd(ACT_LOOK_AT, 0, 0, 0, 0, 1'b0);
        push_cmd(ACT_LOOK_AT, 0, 0, 32'sh01000000, 0, 1'b0);
        push_cmd(ACT_LOOK_AT, 0, 0, -32'sh05000000, 32'sh10000000, 1'b1);
        push_cmd(ACT_LOOK_AT, 32'sh01000000, 32'sh02000000, 32'sh00400000, 0, 1'b0);
        push_cmd(ACT_LOOK_AT, 32'sh01000000, 32'sh02000000, 32'sh00400000, 0, 1'b1);
        push_cmd(ACT_LOOK_AT, 32'sh03000000, -32'sh01000000, 0, 32'sh18000000, 1'b0);
        push_cmd(ACT_LOOK_AT, -32'sh03000000, 32'sh01000000, 32'sh01000000, -32'sh18000000,
                 1'b1);
        push_cmd(ACT_LOOK_AT, 32'sh01000000, 32'sh01000000, 0, 32'sh7fffffff, 1'b0);
        push_cmd(ACT_LOOK_AT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 1'b1);
        push_cmd(ACT_LOOK_AT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                 1'b0);
        push_cmd(ACT_LOOK_AT, 1, 0, 32'sh7fffffff, 0, 1'b0);
        push_cmd(ACT_ROTATE, 32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff,
                 1'b0);
      end
      if (ph == 5) quiet = 1'b1;
      random_cmds(200);
    end

    wait_idle();
    repeat (800) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
src/cou_pkg.sv
src/cou_div.sv
src/cou_isqrt.sv
src/camera_orientation_update.sv
bench/tb_camera_orientation_update.sv
